@@ rtl/core/chol_pkg.sv @@
// ----------------------------------------------------------------------------
// Cholesky factorization package
// Shared constants and types for the factorization core and its arithmetic unit.
// ----------------------------------------------------------------------------
package chol_pkg;

    localparam int DEF_MAX_ORDER     = 8;
    localparam int DEF_FRACTION_BITS = 16;

    localparam int SIZE_W  = 4;
    localparam int THR_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 2;
    localparam int DATA_W  = 32;
    localparam int ACC_W   = 64;

    localparam logic [CIDX_W-1:0] REG_MATRIX_SIZE     = 2'd0;
    localparam logic [CIDX_W-1:0] REG_PIVOT_THRESHOLD = 2'd1;

    typedef enum logic {
        OP_SQRT,
        OP_DIV
    } unit_op_t;

    typedef struct packed {
        logic     start;
        unit_op_t op;
    } unit_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] value;
    } unit_resp_t;

endpackage

@@ rtl/core/cholesky_factorization.sv @@
// ----------------------------------------------------------------------------
// Cholesky factorization core
// Loads the lower triangle of a symmetric matrix, factors it in place and
// streams out the lower-triangular factor.
// ----------------------------------------------------------------------------
// Entries are written one per transfer on start/entry_value, row by row,
// columns 0 to the diagonal; busy stays low while entries are loaded.
// The transfer of the last entry raises busy. The core then walks the
// triangle with one multiplier and one iterative root/divide unit: each
// product term passes through the S_RD_K, S_MUL and S_ACC states; a
// diagonal gets a square root and an off-diagonal a division in the
// bit-per-cycle unit, unless the pivot is bad. The factor is then sent in
// load order, one transfer per S_OUT_RD/S_OUT_EMIT pass on result_valid
// with factor_value, last_entry and failed; busy falls with the last transfer.
// Results cannot be held off; each is present for exactly one cycle.
// Writing matrix_size restarts loading at the first entry. Reset sets order
// 8 and threshold 1 and discards any partial load.
// ----------------------------------------------------------------------------
module cholesky_factorization #(
    parameter int MAX_ORDER     = chol_pkg::DEF_MAX_ORDER,
    parameter int FRACTION_BITS = chol_pkg::DEF_FRACTION_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [chol_pkg::DATA_W-1:0]  entry_value,
    input  logic                                cfg_we,
    input  logic [chol_pkg::CIDX_W-1:0]         cfg_index,
    input  logic [chol_pkg::CFG_W-1:0]          cfg_data,
    output logic                                result_valid,
    output logic signed [chol_pkg::DATA_W-1:0]  factor_value,
    output logic                                last_entry,
    output logic                                failed
);
    import chol_pkg::*;

    localparam int DEPTH = MAX_ORDER * (MAX_ORDER + 1) / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_A,
        S_LD_A,
        S_RD_K,
        S_MUL,
        S_ACC,
        S_PIVOT,
        S_DIV,
        S_WAIT,
        S_WRITE,
        S_OUT_RD,
        S_OUT_EMIT
    } state_t;

    state_t                   state_reg;
    logic [SIZE_W-1:0]        size_reg;
    logic [THR_W-1:0]         thr_reg;
    logic [IW-1:0]            i_reg;
    logic [IW-1:0]            j_reg;
    logic [IW-1:0]            k_reg;
    logic [AW-1:0]            base_i_reg;
    logic [AW-1:0]            base_j_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  prod_reg;
    logic signed [DATA_W-1:0] res_reg;
    logic                     bad_reg;
    logic                     fail_reg;
    logic [MAX_ORDER-1:0]     colbad_reg;
    logic                     valid_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    logic                     out_last_reg;
    logic                     out_failed_reg;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rd0_reg;
    logic signed [DATA_W-1:0] rd1_reg;
    logic [AW-1:0]            raddr0;
    logic [AW-1:0]            raddr1;
    logic                     mem_we;
    logic [AW-1:0]            waddr;
    logic signed [DATA_W-1:0] wdata;

    logic [SIZE_W-1:0]        n_use;
    logic                     row_end;
    logic                     last_row;
    logic                     tri_done;
    logic [AW-1:0]            addr_ij;
    logic [IW:0]              k_inc;
    logic signed [ACC_W-1:0]  acc_init;
    logic signed [ACC_W-1:0]  prod_full;
    logic signed [ACC_W:0]    diff;
    logic signed [ACC_W-1:0]  diff_sat;
    logic                     accept;
    logic                     is_diag;

    unit_req_t                ureq;
    unit_resp_t               uresp;

    assign n_use = (size_reg == '0) ? SIZE_W'(1) :
                   (size_reg > SIZE_W'(MAX_ORDER)) ? SIZE_W'(MAX_ORDER) : size_reg;
    assign row_end  = (j_reg == i_reg);
    assign last_row = ((SIZE_W'(i_reg) + SIZE_W'(1)) == n_use);
    assign tri_done = row_end && last_row;
    assign is_diag  = row_end;
    assign addr_ij  = base_i_reg + AW'(j_reg);
    assign k_inc    = {1'b0, k_reg} + 1'b1;
    assign accept   = start && (state_reg == S_IDLE);
    assign acc_init = ACC_W'(rd0_reg) <<< FRACTION_BITS;
    assign prod_full = rd0_reg * rd1_reg;
    assign diff     = {acc_reg[ACC_W-1], acc_reg} - {prod_reg[ACC_W-1], prod_reg};

    always_comb
    begin
        if (diff > $signed({2'b00, {(ACC_W-1){1'b1}}}))
        begin
            diff_sat = {1'b0, {(ACC_W-1){1'b1}}};
        end
        else if (diff < -$signed({2'b00, {(ACC_W-1){1'b1}}}))
        begin
            diff_sat = {1'b1, {(ACC_W-2){1'b0}}, 1'b1};
        end
        else
        begin
            diff_sat = diff[ACC_W-1:0];
        end
    end

    always_comb
    begin
        raddr0 = addr_ij;
        raddr1 = base_j_reg + AW'(j_reg);
        mem_we = 1'b0;
        waddr  = addr_ij;
        wdata  = entry_value;
        ureq.start = 1'b0;
        ureq.op    = OP_SQRT;
        unique case (state_reg)
            S_IDLE:
            begin
                mem_we = accept;
            end
            S_RD_K:
            begin
                raddr0 = base_i_reg + AW'(k_reg);
                raddr1 = base_j_reg + AW'(k_reg);
            end
            S_PIVOT:
            begin
                ureq.start = is_diag && !acc_reg[ACC_W-1];
            end
            S_DIV:
            begin
                ureq.start = !(colbad_reg[j_reg] || rd1_reg <= 0);
                ureq.op    = OP_DIV;
            end
            S_WRITE:
            begin
                mem_we = 1'b1;
                wdata  = res_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        rd0_reg <= mem[raddr0];
        rd1_reg <= mem[raddr1];
    end

    chol_unit u_unit (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ureq),
        .operand (acc_reg),
        .divisor (rd1_reg),
        .resp    (uresp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            size_reg   <= SIZE_W'(8);
            thr_reg    <= THR_W'(1);
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            base_i_reg <= '0;
            base_j_reg <= '0;
            fail_reg   <= 1'b0;
            bad_reg    <= 1'b0;
            colbad_reg <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MATRIX_SIZE:
                    begin
                        size_reg   <= cfg_data[SIZE_W-1:0];
                        i_reg      <= '0;
                        j_reg      <= '0;
                        base_i_reg <= '0;
                        base_j_reg <= '0;
                        fail_reg   <= 1'b0;
                    end
                    REG_PIVOT_THRESHOLD:
                    begin
                        thr_reg <= cfg_data[THR_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (tri_done)
                        begin
                            i_reg      <= '0;
                            j_reg      <= '0;
                            base_i_reg <= '0;
                            base_j_reg <= '0;
                            colbad_reg <= '0;
                            state_reg  <= S_RD_A;
                        end
                        else if (row_end)
                        begin
                            i_reg      <= i_reg + 1'b1;
                            j_reg      <= '0;
                            base_i_reg <= base_i_reg + AW'(i_reg) + AW'(1);
                        end
                        else
                        begin
                            j_reg <= j_reg + 1'b1;
                        end
                    end
                end
                S_RD_A:
                begin
                    k_reg     <= '0;
                    bad_reg   <= 1'b0;
                    state_reg <= S_LD_A;
                end
                S_LD_A:
                begin
                    acc_reg   <= acc_init;
                    state_reg <= (j_reg != '0) ? S_RD_K : S_PIVOT;
                end
                S_RD_K:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    prod_reg  <= prod_full;
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    acc_reg   <= diff_sat;
                    k_reg     <= k_inc[IW-1:0];
                    state_reg <= (k_inc < {1'b0, j_reg}) ? S_RD_K : S_PIVOT;
                end
                S_PIVOT:
                begin
                    if (!is_diag)
                    begin
                        state_reg <= S_DIV;
                    end
                    else if (acc_reg[ACC_W-1])
                    begin
                        res_reg   <= '0;
                        bad_reg   <= 1'b1;
                        state_reg <= S_WRITE;
                    end
                    else
                    begin
                        state_reg <= S_WAIT;
                    end
                end
                S_DIV:
                begin
                    if (colbad_reg[j_reg] || rd1_reg <= 0)
                    begin
                        res_reg   <= '0;
                        state_reg <= S_WRITE;
                    end
                    else
                    begin
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    if (uresp.done)
                    begin
                        res_reg <= uresp.value;
                        bad_reg <= is_diag &&
                                   (uresp.value <= $signed({16'b0, thr_reg}));
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    if (bad_reg)
                    begin
                        fail_reg          <= 1'b1;
                        colbad_reg[j_reg] <= 1'b1;
                    end
                    if (tri_done)
                    begin
                        i_reg      <= '0;
                        j_reg      <= '0;
                        base_i_reg <= '0;
                        base_j_reg <= '0;
                        state_reg  <= S_OUT_RD;
                    end
                    else
                    begin
                        if (row_end)
                        begin
                            i_reg      <= i_reg + 1'b1;
                            j_reg      <= '0;
                            base_i_reg <= base_i_reg + AW'(i_reg) + AW'(1);
                            base_j_reg <= '0;
                        end
                        else
                        begin
                            j_reg      <= j_reg + 1'b1;
                            base_j_reg <= base_j_reg + AW'(j_reg) + AW'(1);
                        end
                        state_reg <= S_RD_A;
                    end
                end
                S_OUT_RD:
                begin
                    state_reg <= S_OUT_EMIT;
                end
                S_OUT_EMIT:
                begin
                    valid_reg      <= 1'b1;
                    out_value_reg  <= rd0_reg;
                    out_last_reg   <= tri_done;
                    out_failed_reg <= fail_reg;
                    if (tri_done)
                    begin
                        i_reg      <= '0;
                        j_reg      <= '0;
                        base_i_reg <= '0;
                        fail_reg   <= 1'b0;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        if (row_end)
                        begin
                            i_reg      <= i_reg + 1'b1;
                            j_reg      <= '0;
                            base_i_reg <= base_i_reg + AW'(i_reg) + AW'(1);
                        end
                        else
                        begin
                            j_reg <= j_reg + 1'b1;
                        end
                        state_reg <= S_OUT_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = valid_reg;
    assign factor_value = out_value_reg;
    assign last_entry   = out_last_reg;
    assign failed       = out_failed_reg;

endmodule

@@ rtl/core/chol_unit.sv @@
// ----------------------------------------------------------------------------
// Cholesky arithmetic unit
// Iterative floor square root and truncating division, one bit per cycle,
// with saturation of the result to the signed 32-bit range.
// ----------------------------------------------------------------------------
module chol_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  chol_pkg::unit_req_t               req,
    input  logic signed [chol_pkg::ACC_W-1:0] operand,
    input  logic signed [chol_pkg::DATA_W-1:0] divisor,
    output chol_pkg::unit_resp_t              resp
);
    import chol_pkg::*;

    typedef enum logic [1:0] {
        U_IDLE,
        U_RUN,
        U_FIN
    } ustate_t;

    ustate_t               state_reg;
    unit_op_t              op_reg;
    logic                  neg_reg;
    logic [6:0]            cnt_reg;
    logic [ACC_W-1:0]      val_reg;
    logic [ACC_W-1:0]      quo_reg;
    logic [33:0]           rem_reg;
    logic [DATA_W-1:0]     dv_reg;
    logic                  done_reg;
    logic signed [DATA_W-1:0] value_reg;

    logic [33:0] sq_rem;
    logic [33:0] sq_trial;
    logic [32:0] dv_rem;
    logic [ACC_W-1:0] neg_q;

    assign sq_rem   = {rem_reg[31:0], val_reg[ACC_W-1:ACC_W-2]};
    assign sq_trial = {quo_reg[31:0], 2'b01};
    assign dv_rem   = {rem_reg[31:0], val_reg[ACC_W-1]};
    assign neg_q    = -quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                U_IDLE:
                begin
                    if (req.start)
                    begin
                        op_reg  <= req.op;
                        rem_reg <= '0;
                        quo_reg <= '0;
                        dv_reg  <= divisor;
                        neg_reg <= operand[ACC_W-1];
                        if (req.op == OP_SQRT)
                        begin
                            val_reg <= operand;
                            cnt_reg <= 7'd32;
                        end
                        else
                        begin
                            val_reg <= operand[ACC_W-1] ? -operand : operand;
                            cnt_reg <= 7'd64;
                        end
                        state_reg <= U_RUN;
                    end
                end
                U_RUN:
                begin
                    if (op_reg == OP_SQRT)
                    begin
                        val_reg <= val_reg << 2;
                        if (sq_rem >= sq_trial)
                        begin
                            rem_reg <= sq_rem - sq_trial;
                            quo_reg <= {quo_reg[ACC_W-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= sq_rem;
                            quo_reg <= {quo_reg[ACC_W-2:0], 1'b0};
                        end
                    end
                    else
                    begin
                        val_reg <= val_reg << 1;
                        if (dv_rem >= {1'b0, dv_reg})
                        begin
                            rem_reg <= {1'b0, dv_rem - {1'b0, dv_reg}};
                            quo_reg <= {quo_reg[ACC_W-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= {1'b0, dv_rem};
                            quo_reg <= {quo_reg[ACC_W-2:0], 1'b0};
                        end
                    end
                    cnt_reg <= cnt_reg - 7'd1;
                    if (cnt_reg == 7'd1)
                    begin
                        state_reg <= U_FIN;
                    end
                end
                U_FIN:
                begin
                    if (op_reg == OP_SQRT)
                    begin
                        value_reg <= quo_reg[31] ? 32'sh7FFF_FFFF : $signed(quo_reg[31:0]);
                    end
                    else if (neg_reg)
                    begin
                        value_reg <= (quo_reg > 64'h0000_0000_8000_0000) ?
                                     32'sh8000_0000 : $signed(neg_q[31:0]);
                    end
                    else
                    begin
                        value_reg <= (quo_reg > 64'h0000_0000_7FFF_FFFF) ?
                                     32'sh7FFF_FFFF : $signed(quo_reg[31:0]);
                    end
                    done_reg  <= 1'b1;
                    state_reg <= U_IDLE;
                end
                default:
                begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

    assign resp.done  = done_reg;
    assign resp.value = value_reg;

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Cholesky factorization testbench
// Loads lower triangles through the command port and predicts every factor
// entry with an in-bench fixed-point factorization, checked against each
// result transfer. Covers directed corner cases, then random well-formed
// and noise matrices under several size and threshold settings.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import chol_pkg::*;

    localparam int STORE_N = 36;
    localparam int FRAC = 16;
    localparam logic [CIDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CIDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     fail;
    } factor_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic signed [DATA_W-1:0] entry_value;
    logic                     cfg_we;
    logic [CIDX_W-1:0]        cfg_index;
    logic [CFG_W-1:0]         cfg_data;
    logic                     result_valid;
    logic signed [DATA_W-1:0] factor_value;
    logic                     last_entry;
    logic                     failed;

    logic signed [DATA_W-1:0] tri_store [STORE_N];
    int unsigned              loaded;
    bit                       run_failed;
    logic [SIZE_W-1:0]        size_reg;
    logic [THR_W-1:0]         thr_reg;
    factor_t                  factor_q [$];
    int                       errors;
    int                       items_sent;
    bit                       idling_on;

    cholesky_factorization i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .entry_value(entry_value), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .result_valid(result_valid),
        .factor_value(factor_value), .last_entry(last_entry), .failed(failed)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    function automatic int unsigned order_now();
        if (size_reg == 0)
            return 1;
        if (size_reg > 8)
            return 8;
        return 32'(size_reg);
    endfunction

    function automatic longint acc_add(longint a, longint b);
        if (b > 0 && a > ACC_MAX - b)
            return ACC_MAX;
        if (b < 0 && a < -ACC_MAX - b)
            return -ACC_MAX;
        return a + b;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [63:0] int_root(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int unsigned idx(int unsigned i, int unsigned j);
        return (i * (i + 1) / 2 + j) % STORE_N;
    endfunction

    task automatic factor_in_place(int unsigned n);
        bit          bad_col [8];
        longint      acc;
        longint      piv;
        logic signed [31:0] d;
        for (int c = 0; c < 8; c++)
            bad_col[c] = 0;
        for (int unsigned i = 0; i < n; i++)
        begin
            for (int unsigned j = 0; j <= i; j++)
            begin
                acc = longint'(tri_store[idx(i, j)]) * (64'sd1 <<< FRAC);
                for (int unsigned k = 0; k < j; k++)
                    acc = acc_add(acc, -(longint'(tri_store[idx(i, k)])
                                        * longint'(tri_store[idx(j, k)])));
                if (j == i)
                begin
                    d = 0;
                    if (acc >= 0)
                        d = clamp32(longint'(int_root(acc)));
                    if (acc < 0 || longint'(d) <= longint'(thr_reg))
                    begin
                        run_failed = 1;
                        bad_col[j] = 1;
                    end
                    tri_store[idx(i, i)] = d;
                end
                else
                begin
                    piv = longint'(tri_store[idx(j, j)]);
                    tri_store[idx(i, j)] = 0;
                    if (!bad_col[j] && piv > 0)
                        tri_store[idx(i, j)] = clamp32(acc / piv);
                end
            end
        end
    endtask

    task automatic predict_entry(logic signed [31:0] v);
        int unsigned n;
        int unsigned total;
        factor_t     f;
        n = order_now();
        total = n * (n + 1) / 2;
        if (loaded >= total)
            loaded = 0;
        tri_store[loaded % STORE_N] = v;
        loaded++;
        if (loaded < total)
            return;
        factor_in_place(n);
        for (int unsigned k = 0; k < total; k++)
        begin
            f.value = tri_store[k];
            f.last = (k + 1 == total);
            f.fail = run_failed;
            factor_q.push_back(f);
        end
        loaded = 0;
        run_failed = 0;
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h at %t", what, got, want, $realtime);
    endtask

    always @(posedge clk)
    begin
        factor_t f;
        if (rst_n && result_valid)
        begin
            if (factor_q.size() == 0)
                report("unexpected transfer", factor_value, '0);
            else
            begin
                f = factor_q.pop_front();
                if (factor_value !== f.value)
                    report("factor_value", factor_value, f.value);
                if (last_entry !== f.last)
                    report("last_entry", 32'(last_entry), 32'(f.last));
                if (failed !== f.fail)
                    report("failed", 32'(failed), 32'(f.fail));
            end
        end
    end

    task automatic send_entry(logic signed [31:0] v);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        start <= 1'b1;
        entry_value <= v;
        do
            @(posedge clk);
        while (busy);
        predict_entry(v);
        items_sent++;
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] ri, logic [CFG_W-1:0] val);
        start <= 1'b0;
        while (factor_q.size() != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= ri;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (ri == REG_MATRIX_SIZE)
        begin
            size_reg = val[SIZE_W-1:0];
            loaded = 0;
            run_failed = 0;
        end
        else if (ri == REG_PIVOT_THRESHOLD)
            thr_reg = val[THR_W-1:0];
    endtask

    // Well-formed input: A = M * M^T with M lower triangular in Q8, plus small noise when noisy is set.
    task automatic send_spd(int unsigned n, bit noisy);
        int m [8][8];
        int a;
        for (int i = 0; i < 8; i++)
            for (int j = 0; j < 8; j++)
                m[i][j] = (j > i) ? 0 : (j == i) ? $urandom_range(64, 1024)
                                                 : $urandom_range(0, 1024) - 512;
        for (int i = 0; i < n; i++)
            for (int j = 0; j <= i; j++)
            begin
                a = 0;
                for (int k = 0; k < 8; k++)
                    a += m[i][k] * m[j][k];
                if (noisy)
                    a += $urandom_range(0, 255) - 128;
                send_entry(a);
            end
    endtask

    task automatic test_reset_defaults();
        send_spd(8, 0);
    endtask

    task automatic test_directed();
        write_reg(REG_MATRIX_SIZE, 16'd1);
        send_entry(32'sh7FFF_FFFF);
        send_entry(32'sh8000_0000);
        send_entry(32'sh0000_0000);
        send_entry(32'sh0000_0001);
        write_reg(REG_PIVOT_THRESHOLD, 16'hFFFF);
        send_entry(32'sh0001_0000);
        send_entry(32'sh0000_FFFF);
        write_reg(REG_PIVOT_THRESHOLD, 16'h0000);
        send_entry(32'sh0000_0001);
        write_reg(REG_MATRIX_SIZE, 16'd0);
        send_entry(32'sh0004_0000);
        write_reg(REG_MATRIX_SIZE, 16'd2);
        send_entry(32'sh0004_0000);
        send_entry(32'sh7FFF_FFFF);
        send_entry(32'sh8000_0000);
        send_entry(32'sh0000_0000);
        send_entry(32'sh0004_0000);
        send_entry(32'sh0001_0000);
        write_reg(REG_MATRIX_SIZE, 16'd3);
        send_entry(32'sh0001_0000);
        send_entry(32'sh0000_8000);
        write_reg(REG_SPARE_A, 16'hFFFF);
        write_reg(REG_SPARE_B, 16'h0001);
        write_reg(REG_MATRIX_SIZE, 16'd2);
        send_entry(32'sh0009_0000);
        send_entry(32'shFFFA_0000);
        send_entry(32'sh0005_0000);
    endtask

    task automatic test_random();
        int unsigned n;
        logic [CFG_W-1:0] sz;
        while (items_sent < 215)
        begin
            if (items_sent > 185)
                idling_on = 0;
            case ($urandom_range(0, 5))
                0: sz = {12'($urandom_range(0, 4095)), 4'($urandom_range(9, 15))};
                1: sz = {12'($urandom_range(0, 4095)), 4'd0};
                2: sz = 16'd8;
                default: sz = {12'($urandom_range(0, 4095)), 4'($urandom_range(1, 4))};
            endcase
            write_reg(REG_MATRIX_SIZE, sz);
            case ($urandom_range(0, 3))
                0: write_reg(REG_PIVOT_THRESHOLD, 16'h0000);
                1: write_reg(REG_PIVOT_THRESHOLD, 16'hFFFF);
                default: write_reg(REG_PIVOT_THRESHOLD, CFG_W'($urandom_range(0, 4096)));
            endcase
            n = order_now();
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 9) < 7)
                    send_spd(n, $urandom_range(0, 1) == 1);
                else
                    repeat (n * (n + 1) / 2) send_entry($urandom);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        entry_value = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        items_sent = 0;
        idling_on = 1;
        loaded = 0;
        run_failed = 0;
        size_reg = 4'd8;
        thr_reg = 16'd1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed();
        test_random();
        start <= 1'b0;
        while (factor_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
